### design/gdpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the garage door position controller.
// Used by the configuration registers, the update logic and the top level.
package gdpc_pkg;

    // Request kind codes.
    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_OPEN_SW   = 3'd1;
    localparam logic [2:0] KIND_CLOSED_SW = 3'd2;
    localparam logic [2:0] KIND_OPEN_CMD  = 3'd3;
    localparam logic [2:0] KIND_CLOSE_CMD = 3'd4;
    localparam logic [2:0] KIND_BUTTON    = 3'd5;
    // Spare kind codes; such requests leave the door state untouched.
    localparam logic [2:0] KIND_SPARE_LO  = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

    // Door position codes.
    localparam logic [2:0] POS_STARTUP = 3'd0;
    localparam logic [2:0] POS_UNKNOWN = 3'd1;
    localparam logic [2:0] POS_CLOSED  = 3'd2;
    localparam logic [2:0] POS_OPEN    = 3'd3;
    localparam logic [2:0] POS_C2O     = 3'd4;
    localparam logic [2:0] POS_O2C     = 3'd5;
    localparam logic [2:0] POS_MC2O    = 3'd6;
    localparam logic [2:0] POS_MO2C    = 3'd7;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GREEN_ON    = 3'd0;
    localparam logic [2:0] CFG_IDLE_OFF    = 3'd1;
    localparam logic [2:0] CFG_MOVING_OFF  = 3'd2;
    localparam logic [2:0] CFG_MANUAL_OFF  = 3'd3;
    localparam logic [2:0] CFG_RED_FLASH   = 3'd4;
    localparam logic [2:0] CFG_RELAY_PULSE = 3'd5;
    localparam logic [2:0] CFG_SHORT_PRESS = 3'd6;
    localparam logic [2:0] CFG_LONG_PRESS  = 3'd7;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Configuration reset values.
    localparam logic [15:0] GREEN_ON_RST    = 16'd200;
    localparam logic [15:0] IDLE_OFF_RST    = 16'd5000;
    localparam logic [15:0] MOVING_OFF_RST  = 16'd500;
    localparam logic [15:0] MANUAL_OFF_RST  = 16'd1000;
    localparam logic [15:0] RED_FLASH_RST   = 16'd1000;
    localparam logic [15:0] RELAY_PULSE_RST = 16'd500;
    localparam logic [15:0] SHORT_PRESS_RST = 16'd1000;
    localparam logic [15:0] LONG_PRESS_RST  = 16'd3000;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic        sw_level;
        logic [15:0] press_ms;
    } req_t;

    typedef struct packed {
        logic [2:0] door_state;
        logic       moving;
        logic       lock_flag;
        logic       relay_on;
        logic       green_on;
        logic       red_on;
        logic       refused;
    } rsp_t;

    typedef struct packed {
        logic [15:0] green_on_ms;
        logic [15:0] idle_off_ms;
        logic [15:0] moving_off_ms;
        logic [15:0] manual_off_ms;
        logic [15:0] red_flash_ms;
        logic [15:0] relay_pulse_ms;
        logic [15:0] short_press_ms;
        logic [15:0] long_press_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  position;
        logic        moving;
        logic        locked;
        logic        open_sw;
        logic        closed_sw;
        logic        green_level;
        logic [15:0] green_elapsed;
        logic        red_level;
        logic [15:0] red_remaining;
        logic [15:0] relay_remaining;
    } state_t;

endpackage

### design/gdpc_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file for the garage door position controller.
// Depends on gdpc_pkg for the register indexes, reset values and cfg_t.
module gdpc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gdpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gdpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output gdpc_pkg::cfg_t                      cfg
);

    gdpc_pkg::cfg_t cfg_reg;

    // Indexed write into the register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.green_on_ms    <= gdpc_pkg::GREEN_ON_RST;
            cfg_reg.idle_off_ms    <= gdpc_pkg::IDLE_OFF_RST;
            cfg_reg.moving_off_ms  <= gdpc_pkg::MOVING_OFF_RST;
            cfg_reg.manual_off_ms  <= gdpc_pkg::MANUAL_OFF_RST;
            cfg_reg.red_flash_ms   <= gdpc_pkg::RED_FLASH_RST;
            cfg_reg.relay_pulse_ms <= gdpc_pkg::RELAY_PULSE_RST;
            cfg_reg.short_press_ms <= gdpc_pkg::SHORT_PRESS_RST;
            cfg_reg.long_press_ms  <= gdpc_pkg::LONG_PRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gdpc_pkg::CFG_GREEN_ON:    cfg_reg.green_on_ms    <= cfg_wdata;
                gdpc_pkg::CFG_IDLE_OFF:    cfg_reg.idle_off_ms    <= cfg_wdata;
                gdpc_pkg::CFG_MOVING_OFF:  cfg_reg.moving_off_ms  <= cfg_wdata;
                gdpc_pkg::CFG_MANUAL_OFF:  cfg_reg.manual_off_ms  <= cfg_wdata;
                gdpc_pkg::CFG_RED_FLASH:   cfg_reg.red_flash_ms   <= cfg_wdata;
                gdpc_pkg::CFG_RELAY_PULSE: cfg_reg.relay_pulse_ms <= cfg_wdata;
                gdpc_pkg::CFG_SHORT_PRESS: cfg_reg.short_press_ms <= cfg_wdata;
                gdpc_pkg::CFG_LONG_PRESS:  cfg_reg.long_press_ms  <= cfg_wdata;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/gdpc_update.sv
`timescale 1ns / 1ps
// Next-state and response logic for one request of the door controller.
// Depends on gdpc_pkg for req_t, rsp_t, cfg_t, state_t and the codes.
module gdpc_update (
    input  gdpc_pkg::req_t   req,
    input  gdpc_pkg::state_t st,
    input  gdpc_pkg::cfg_t   cfg,
    output gdpc_pkg::state_t st_next,
    output gdpc_pkg::rsp_t   rsp
);

    gdpc_pkg::state_t ns;
    logic             refused;
    logic             blinking;
    logic [15:0]      off_time;

    // Green LED off time follows the door position.
    always_comb
    begin
        blinking = 1'b1;
        off_time = '0;
        case (st.position)
            gdpc_pkg::POS_CLOSED, gdpc_pkg::POS_OPEN:  off_time = cfg.idle_off_ms;
            gdpc_pkg::POS_C2O, gdpc_pkg::POS_O2C:      off_time = cfg.moving_off_ms;
            gdpc_pkg::POS_MC2O, gdpc_pkg::POS_MO2C:    off_time = cfg.manual_off_ms;
            default:                                   blinking = 1'b0;
        endcase
    end

    // State update for each kind of request.
    always_comb
    begin
        ns      = st;
        refused = 1'b0;
        case (req.kind)
            gdpc_pkg::KIND_TICK:
            begin
                if (ns.green_elapsed != gdpc_pkg::COUNT_MAX)
                begin
                    ns.green_elapsed = ns.green_elapsed + 16'd1;
                end
                if (blinking)
                begin
                    if (!ns.green_level && ns.green_elapsed >= off_time)
                    begin
                        ns.green_level   = 1'b1;
                        ns.green_elapsed = '0;
                    end
                    if (ns.green_level && ns.green_elapsed >= cfg.green_on_ms)
                    begin
                        ns.green_level   = 1'b0;
                        ns.green_elapsed = '0;
                    end
                end
                // Both countdowns darken the red LED when they run out.
                if (ns.red_remaining != '0)
                begin
                    ns.red_remaining = ns.red_remaining - 16'd1;
                    if (ns.red_remaining == '0)
                    begin
                        ns.red_level = 1'b0;
                    end
                end
                if (ns.relay_remaining != '0)
                begin
                    ns.relay_remaining = ns.relay_remaining - 16'd1;
                    if (ns.relay_remaining == '0)
                    begin
                        ns.red_level = 1'b0;
                    end
                end
            end

            gdpc_pkg::KIND_OPEN_SW, gdpc_pkg::KIND_CLOSED_SW:
            begin
                if (req.kind == gdpc_pkg::KIND_OPEN_SW)
                begin
                    ns.open_sw = req.sw_level;
                end
                else
                begin
                    ns.closed_sw = req.sw_level;
                end
                case (st.position)
                    gdpc_pkg::POS_STARTUP, gdpc_pkg::POS_UNKNOWN:
                    begin
                        if (ns.closed_sw)
                        begin
                            ns.position  = gdpc_pkg::POS_CLOSED;
                            ns.red_level = 1'b0;
                        end
                        else if (ns.open_sw)
                        begin
                            ns.position  = gdpc_pkg::POS_OPEN;
                            ns.red_level = 1'b0;
                        end
                        else
                        begin
                            ns.red_level = 1'b1;
                        end
                    end
                    gdpc_pkg::POS_CLOSED:
                    begin
                        if (!ns.closed_sw && !ns.moving)
                        begin
                            ns.moving   = 1'b1;
                            ns.position = gdpc_pkg::POS_MC2O;
                        end
                    end
                    gdpc_pkg::POS_OPEN:
                    begin
                        if (!ns.open_sw && !ns.moving)
                        begin
                            ns.moving   = 1'b1;
                            ns.position = gdpc_pkg::POS_MO2C;
                        end
                    end
                    default:
                    begin
                        // A commanded move starts once the door leaves its end switch.
                        if (st.position == gdpc_pkg::POS_C2O && !ns.closed_sw)
                        begin
                            ns.moving = 1'b1;
                        end
                        if (st.position == gdpc_pkg::POS_O2C && !ns.open_sw)
                        begin
                            ns.moving = 1'b1;
                        end
                        // Settle at whichever end switch is now closed.
                        if (ns.moving && ns.open_sw)
                        begin
                            ns.position = gdpc_pkg::POS_OPEN;
                            ns.moving   = 1'b0;
                        end
                        if (ns.moving && ns.closed_sw)
                        begin
                            ns.position = gdpc_pkg::POS_CLOSED;
                            ns.moving   = 1'b0;
                        end
                    end
                endcase
            end

            gdpc_pkg::KIND_OPEN_CMD, gdpc_pkg::KIND_CLOSE_CMD:
            begin
                if (!st.locked)
                begin
                    if (req.kind == gdpc_pkg::KIND_OPEN_CMD
                        && st.position == gdpc_pkg::POS_CLOSED)
                    begin
                        ns.position        = gdpc_pkg::POS_C2O;
                        ns.relay_remaining = cfg.relay_pulse_ms;
                        ns.red_level       = 1'b1;
                    end
                    else if (req.kind == gdpc_pkg::KIND_CLOSE_CMD
                             && st.position == gdpc_pkg::POS_OPEN)
                    begin
                        ns.position        = gdpc_pkg::POS_O2C;
                        ns.relay_remaining = cfg.relay_pulse_ms;
                        ns.red_level       = 1'b1;
                    end
                    else
                    begin
                        ns.red_remaining = cfg.red_flash_ms;
                        ns.red_level     = 1'b1;
                        refused          = 1'b1;
                    end
                end
            end

            gdpc_pkg::KIND_BUTTON:
            begin
                // Short press pulses the relay while unlocked, long press toggles the lock.
                if (!st.locked && req.press_ms < cfg.short_press_ms)
                begin
                    ns.relay_remaining = cfg.relay_pulse_ms;
                    ns.red_level       = 1'b1;
                end
                else if (req.press_ms > cfg.long_press_ms)
                begin
                    ns.locked = !st.locked;
                end
            end

            default:
            begin
                ns = st;
            end
        endcase
    end

    // The response reflects the state after the request.
    always_comb
    begin
        rsp.door_state = ns.position;
        rsp.moving     = ns.moving;
        rsp.lock_flag  = ns.locked;
        rsp.relay_on   = (ns.relay_remaining != '0);
        rsp.green_on   = ns.green_level;
        rsp.red_on     = ns.red_level;
        rsp.refused    = refused;
    end

    assign st_next = ns;

endmodule

### design/garage_door_position_controller_core.sv
`timescale 1ns / 1ps
// Garage door position controller, top level.
// Pipeline: an accepted request is held in an input register and its response in a response
// register, with a single combinational update between them. Throughput: one request per
// cycle while responses are taken; a response that waits on rsp_ready stalls the pipe.
// Reset: position startup, both LEDs on, all timers and the lock cleared,
// configuration registers at their default values. Depends on gdpc_pkg.
module garage_door_position_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  gdpc_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output gdpc_pkg::rsp_t                      rsp,
    input  logic                                cfg_we,
    input  logic [gdpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gdpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    gdpc_pkg::cfg_t   cfg;
    gdpc_pkg::req_t   req_reg;
    logic             req_valid_reg;
    gdpc_pkg::state_t state_reg;
    gdpc_pkg::state_t state_next;
    gdpc_pkg::rsp_t   rsp_reg;
    gdpc_pkg::rsp_t   rsp_next;
    logic             rsp_valid_reg;
    logic             stall;
    logic             advance;

    gdpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gdpc_update u_update (
        .req     (req_reg),
        .st      (state_reg),
        .cfg     (cfg),
        .st_next (state_next),
        .rsp     (rsp_next)
    );

    // Pipeline control: the whole pipe holds only while a response waits.
    assign stall     = rsp_valid_reg && !rsp_ready;
    assign advance   = req_valid_reg && !stall;
    assign req_ready = !req_valid_reg || !stall;

    // Control and door state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg             <= 1'b0;
            rsp_valid_reg             <= 1'b0;
            state_reg.position        <= gdpc_pkg::POS_STARTUP;
            state_reg.moving          <= 1'b0;
            state_reg.locked          <= 1'b0;
            state_reg.open_sw         <= 1'b0;
            state_reg.closed_sw       <= 1'b0;
            state_reg.green_level     <= 1'b1;
            state_reg.green_elapsed   <= '0;
            state_reg.red_level       <= 1'b1;
            state_reg.red_remaining   <= '0;
            state_reg.relay_remaining <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (!stall)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The moving flag is only ever set in one of the movement positions.
    a_moving_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.moving |-> (state_reg.position == gdpc_pkg::POS_C2O
                              || state_reg.position == gdpc_pkg::POS_O2C
                              || state_reg.position == gdpc_pkg::POS_MC2O
                              || state_reg.position == gdpc_pkg::POS_MO2C))
        else $error("moving flag set outside a movement position");

    // A refused command can only come while the lock is off.
    a_refused_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.refused) |-> !rsp_reg.lock_flag)
        else $error("refused response while locked");

    // Once the position leaves startup it never returns there.
    a_no_startup_return: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.position != gdpc_pkg::POS_STARTUP)
        |=> (state_reg.position != gdpc_pkg::POS_STARTUP))
        else $error("position returned to startup");

    // A request that moves on produces a response in the next cycle.
    a_advance_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("advanced request produced no response");

    // The door state only changes when a request moves on.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("door state changed without a request");

endmodule
